FILE: hw/rtl/rast_pkg.sv
// Shared constants and types of the range add and range sum tree.
`default_nettype none
package rast_pkg;
   localparam int MaxElements = 1024;
   localparam int TreeNodes   = 4096;
   localparam int NodeW       = $clog2(TreeNodes);
   localparam int IdxW        = 11;
   localparam int SumW        = 64;
   localparam int AddW        = 32;
   localparam int StackDepth  = 32;
   localparam int SpIdxW      = $clog2(StackDepth);
   localparam int SpW         = SpIdxW + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_VISIT,
      ST_LEAF,
      ST_PUSH_CHK,
      ST_PUSH_L,
      ST_PUSH_R,
      ST_PUSH_Z,
      ST_DESCEND,
      ST_POP,
      ST_FIX_L,
      ST_FIX_R,
      ST_FIX_WR,
      ST_DONE
   } state_type;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic            right_done;
      logic [NodeW-1:0] node;
      logic [IdxW-1:0]  lo;
      logic [IdxW-1:0]  hi;
   } frame_type;
endpackage
`default_nettype wire

FILE: hw/rtl/range_add_range_sum_tree.sv
// Top level: segment tree with lazy add tags, range add and range sum.
//
//  channel  direction  payload
//  req_     in         tuser: opcode; tdata: first_index, end_index, addend
//  rsp_     out        tdata: range_sum (query transfers only)
//  csr_     in         length_in_use write, no read-back
//
// A node outside the range passes through VISIT and POP, one inside it also through LEAF.
// A split node passes through PUSH_CHK and DESCEND, plus PUSH_L, PUSH_R and PUSH_Z when
// it carries a pending tag; an add also rebuilds its sum in FIX_L, FIX_R and FIX_WR.
// These steps come from the single read and write port of the sum and tag memories.
// After reset and after every csr_ write, a clearing pass over all 4096 nodes
// zeroes both memories while req_tready stays low.
// A query result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module range_add_range_sum_tree (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [0:0]  req_tuser,   // opcode
   input  wire logic [55:0] req_tdata,   // first_index, end_index, addend, zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // range_sum
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data  // length_in_use
);
   localparam int NodeW  = rast_pkg::NodeW;
   localparam int IdxW   = rast_pkg::IdxW;
   localparam int SumW   = rast_pkg::SumW;
   localparam int SpIdxW = rast_pkg::SpIdxW;
   localparam int SpW    = rast_pkg::SpW;

   rast_pkg::state_type  state_ff, state_in;
   rast_pkg::opcode_type op_ff, op_in;
   rast_pkg::frame_type  stack_ff [rast_pkg::StackDepth];
   rast_pkg::frame_type  top;

   logic [IdxW-1:0]  len_ff, len_in;
   logic [IdxW-1:0]  l_ff, l_in, r_ff, r_in;
   logic [SumW-1:0]  k_ff, k_in;
   logic [NodeW-1:0] node_ff, node_in;
   logic [IdxW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [SumW-1:0]  acc_ff, acc_in;
   logic [SumW-1:0]  t_ff, t_in;
   logic [SumW-1:0]  prod_ff, prod_in;
   logic [SumW-1:0]  suml_ff, suml_in;
   logic [SpW-1:0]   sp_ff, sp_in;
   logic [SpW-1:0]   sp_m1;
   logic [NodeW-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SumW-1:0]  rsp_data_ff, rsp_data_in;

   logic             push_en, mark_right;
   logic [IdxW:0]    mid_wide, top_mid_wide;
   logic [IdxW-1:0]  mid, top_mid;
   logic [NodeW-1:0] left_node, right_node;
   logic             disjoint, contained;
   logic             accept, req_ok, req_nonempty;
   logic [IdxW-1:0]  req_first, req_end;
   logic [10:0]      csr_sat;

   logic             sum_we, pend_we;
   logic [NodeW-1:0] sum_wa, pend_wa, rd_addr;
   logic [SumW-1:0]  sum_wd, pend_wd, sum_rd, pend_rd;

   rast_ram #(.WIDTH(SumW), .DEPTH(rast_pkg::TreeNodes)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_wa),
      .wr_data (sum_wd),
      .rd_addr (rd_addr),
      .rd_data (sum_rd)
   );

   rast_ram #(.WIDTH(SumW), .DEPTH(rast_pkg::TreeNodes)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wa),
      .wr_data (pend_wd),
      .rd_addr (rd_addr),
      .rd_data (pend_rd)
   );

   assign req_first    = req_tdata[10:0];
   assign req_end      = req_tdata[21:11];
   assign accept       = req_tvalid && req_tready;
   assign req_ok       = (req_first <= req_end) && (req_end <= len_ff);
   assign req_nonempty = req_first < req_end;

   assign mid_wide   = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign mid        = mid_wide[IdxW-1:0];
   assign left_node  = {node_ff[NodeW-2:0], 1'b0};
   assign right_node = {node_ff[NodeW-2:0], 1'b1};
   assign disjoint   = (r_ff <= lo_ff) || (l_ff >= hi_ff);
   assign contained  = (l_ff <= lo_ff) && (hi_ff <= r_ff);

   assign sp_m1        = sp_ff - SpW'(1);
   assign top          = stack_ff[sp_m1[SpIdxW-1:0]];
   assign top_mid_wide = ({1'b0, top.lo} + {1'b0, top.hi}) >> 1;
   assign top_mid      = top_mid_wide[IdxW-1:0];

   assign csr_sat = (csr_wr_data == 11'd0) ? 11'd1 :
                    (csr_wr_data > 11'(rast_pkg::MaxElements)) ?
                    11'(rast_pkg::MaxElements) : csr_wr_data;

   assign req_tready = (state_ff == rast_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rast_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ok && req_nonempty) begin
                  state_in = rast_pkg::ST_VISIT;
               end else if (rast_pkg::opcode_type'(req_tuser[0]) == rast_pkg::OP_QUERY) begin
                  state_in = rast_pkg::ST_DONE;
               end
            end
         end
         rast_pkg::ST_CLEAR: begin
            if (clr_ff == {NodeW{1'b1}}) begin
               state_in = rast_pkg::ST_IDLE;
            end
         end
         rast_pkg::ST_VISIT: begin
            if (disjoint) begin
               state_in = rast_pkg::ST_POP;
            end else if (contained) begin
               state_in = rast_pkg::ST_LEAF;
            end else begin
               state_in = rast_pkg::ST_PUSH_CHK;
            end
         end
         rast_pkg::ST_LEAF:     state_in = rast_pkg::ST_POP;
         rast_pkg::ST_PUSH_CHK: begin
            state_in = (pend_rd == '0) ? rast_pkg::ST_DESCEND : rast_pkg::ST_PUSH_L;
         end
         rast_pkg::ST_PUSH_L:   state_in = rast_pkg::ST_PUSH_R;
         rast_pkg::ST_PUSH_R:   state_in = rast_pkg::ST_PUSH_Z;
         rast_pkg::ST_PUSH_Z:   state_in = rast_pkg::ST_DESCEND;
         rast_pkg::ST_DESCEND:  state_in = rast_pkg::ST_VISIT;
         rast_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               state_in = (op_ff == rast_pkg::OP_QUERY) ? rast_pkg::ST_DONE
                                                        : rast_pkg::ST_IDLE;
            end else if (!top.right_done) begin
               state_in = rast_pkg::ST_VISIT;
            end else if (op_ff == rast_pkg::OP_ADD) begin
               state_in = rast_pkg::ST_FIX_L;
            end
         end
         rast_pkg::ST_FIX_L:    state_in = rast_pkg::ST_FIX_R;
         rast_pkg::ST_FIX_R:    state_in = rast_pkg::ST_FIX_WR;
         rast_pkg::ST_FIX_WR:   state_in = rast_pkg::ST_POP;
         rast_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = rast_pkg::ST_IDLE;
            end
         end
         default: state_in = rast_pkg::ST_IDLE;
      endcase
      if (csr_wr_en) begin
         state_in = rast_pkg::ST_CLEAR;
      end
   end

   always_comb begin
      op_in        = op_ff;
      len_in       = len_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      node_in      = node_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      suml_in      = suml_ff;
      sp_in        = sp_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      push_en      = 1'b0;
      mark_right   = 1'b0;
      sum_we       = 1'b0;
      pend_we      = 1'b0;
      sum_wa       = node_ff;
      pend_wa      = node_ff;
      sum_wd       = '0;
      pend_wd      = '0;
      rd_addr      = node_ff;
      unique case (state_ff)
         rast_pkg::ST_IDLE: begin
            if (accept) begin
               op_in   = rast_pkg::opcode_type'(req_tuser[0]);
               l_in    = req_first;
               r_in    = req_end;
               k_in    = {{(SumW - rast_pkg::AddW){req_tdata[53]}}, req_tdata[53:22]};
               node_in = NodeW'(1);
               lo_in   = '0;
               hi_in   = len_ff;
               acc_in  = '0;
               sp_in   = '0;
            end
         end
         rast_pkg::ST_CLEAR: begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
            sum_wa  = clr_ff;
            pend_wa = clr_ff;
            clr_in  = clr_ff + NodeW'(1);
         end
         rast_pkg::ST_VISIT: begin
            prod_in = SumW'(k_ff * {{(SumW - IdxW){1'b0}}, hi_ff - lo_ff});
         end
         rast_pkg::ST_LEAF: begin
            if (op_ff == rast_pkg::OP_ADD) begin
               sum_we  = 1'b1;
               pend_we = 1'b1;
               sum_wd  = sum_rd + prod_ff;
               pend_wd = pend_rd + k_ff;
            end else begin
               acc_in = acc_ff + sum_rd;
            end
         end
         rast_pkg::ST_PUSH_CHK: begin
            t_in    = pend_rd;
            rd_addr = left_node;
            prod_in = SumW'(pend_rd * {{(SumW - IdxW){1'b0}}, mid - lo_ff});
         end
         rast_pkg::ST_PUSH_L: begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
            sum_wa  = left_node;
            pend_wa = left_node;
            sum_wd  = sum_rd + prod_ff;
            pend_wd = pend_rd + t_ff;
            rd_addr = right_node;
            prod_in = SumW'(t_ff * {{(SumW - IdxW){1'b0}}, hi_ff - mid});
         end
         rast_pkg::ST_PUSH_R: begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
            sum_wa  = right_node;
            pend_wa = right_node;
            sum_wd  = sum_rd + prod_ff;
            pend_wd = pend_rd + t_ff;
         end
         rast_pkg::ST_PUSH_Z: begin
            pend_we = 1'b1;
         end
         rast_pkg::ST_DESCEND: begin
            push_en = 1'b1;
            sp_in   = sp_ff + SpW'(1);
            node_in = left_node;
            hi_in   = mid;
         end
         rast_pkg::ST_POP: begin
            if (sp_ff != '0) begin
               if (!top.right_done) begin
                  mark_right = 1'b1;
                  node_in    = {top.node[NodeW-2:0], 1'b1};
                  lo_in      = top_mid;
                  hi_in      = top.hi;
               end else begin
                  sp_in   = sp_m1;
                  node_in = top.node;
                  lo_in   = top.lo;
                  hi_in   = top.hi;
               end
            end
         end
         rast_pkg::ST_FIX_L: begin
            rd_addr = left_node;
         end
         rast_pkg::ST_FIX_R: begin
            suml_in = sum_rd;
            rd_addr = right_node;
         end
         rast_pkg::ST_FIX_WR: begin
            sum_we = 1'b1;
            sum_wd = suml_ff + sum_rd;
         end
         rast_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         len_in = csr_sat;
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rast_pkg::ST_CLEAR;
         len_ff       <= IdxW'(rast_pkg::MaxElements);
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      node_ff     <= node_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      suml_ff     <= suml_in;
      rsp_data_ff <= rsp_data_in;
      if (push_en) begin
         stack_ff[sp_ff[SpIdxW-1:0]] <= '{right_done: 1'b0, node: node_ff,
                                         lo: lo_ff, hi: hi_ff};
      end else if (mark_right) begin
         stack_ff[sp_m1[SpIdxW-1:0]].right_done <= 1'b1;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/rast_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module rast_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
